@@ design/sm4_pkg.sv @@
// Shared definitions for the SM4 block cipher: S-box, FK and CK constants,
// and the word functions used by the round unit and the top-level sequencer.
// No dependencies.
package sm4_pkg;

  localparam int ROUND_COUNT_DEF = 32;
  localparam int KEY_WORDS       = 4;
  localparam int KEY_IDX_W       = 2;
  localparam int WORD_W          = 32;
  localparam int CK_IDX_W        = 5;

  localparam logic [WORD_W-1:0] FK [KEY_WORDS] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  localparam logic [7:0] SBOX [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // Byte j of CK word i is (4*i + j) * 7, kept to eight bits.
  function automatic logic [WORD_W-1:0] ck_word(input logic [CK_IDX_W-1:0] i);
    logic [WORD_W-1:0] w;
    logic [7:0]        b;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = ({1'b0, i, 2'b00} + 8'(j)) * 8'd7;
      w = {w[WORD_W-9:0], b};
    end
    return w;
  endfunction

endpackage

@@ design/sm4_block_cipher.sv @@
// SM4 block cipher top level: key registers, sequencer, work words and
// output register. Depends on sm4_pkg, sm4_round_fn and sm4_rk_mem.
//
//   channel   direction  payload
//   in_       request    tuser: opcode (0 encrypt, 1 decrypt); tdata: block_hi, block_lo
//   out_      result     tdata: result_hi, result_lo
//   cfg_      write      cfg_addr selects key word 0..3, cfg_wdata is the word
//
// One shared S-box/linear unit does one round per cycle. A block passes
// an accept step, 32 rounds and a move of the result into the output
// register before a new request is taken. A key write starts a key expansion
// (load step, 32 rounds) on the same unit; requests wait until it ends.
// A stalled output holds the sequencer in its done state. Reset is
// synchronous; round keys are valid only after a key write.
module sm4_block_cipher
  import sm4_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [127:0]         in_tdata,   // [63:0] block_hi, [127:64] block_lo
  input  logic [0:0]           in_tuser,   // [0] opcode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [127:0]         out_tdata,  // [63:0] result_hi, [127:64] result_lo
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_addr,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  localparam int CW = $clog2(ROUND_COUNT);
  localparam logic [CW-1:0] LAST = CW'(ROUND_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_KEY_LOAD, ST_KEY_RUN, ST_BLK_RUN, ST_DONE
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              dec_r;
  logic [WORD_W-1:0] key_r [KEY_WORDS];
  logic [WORD_W-1:0] x_r [4];
  logic              out_valid_r;
  logic [127:0]      out_data_r;

  logic              in_accept;
  logic              key_mode;
  logic              dec_sel;
  logic [CW-1:0]     rd_idx;
  logic [CW-1:0]     rk_raddr;
  logic [WORD_W-1:0] rk_rdata;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] t;
  logic [WORD_W-1:0] word_nxt;
  logic              out_free;

  // A key write takes priority, so a request offered in the same cycle waits.
  assign in_tready = (state_r == ST_IDLE) && !cfg_we;
  assign in_accept = in_tvalid && in_tready;
  assign key_mode  = (state_r == ST_KEY_RUN);
  assign cnt_nxt   = cnt_r + CW'(1);
  assign out_free  = !out_valid_r || out_tready;

  // The read address runs one round ahead of the data path; decryption
  // walks the round keys from the top down.
  assign dec_sel  = (state_r == ST_IDLE) ? in_tuser[0] : dec_r;
  assign rd_idx   = (state_r == ST_BLK_RUN) ? cnt_nxt : '0;
  assign rk_raddr = dec_sel ? (LAST - rd_idx) : rd_idx;

  assign mix      = x_r[1] ^ x_r[2] ^ x_r[3] ^
                    (key_mode ? ck_word(CK_IDX_W'(cnt_r)) : rk_rdata);
  assign word_nxt = x_r[0] ^ t;

  sm4_round_fn u_round (
    .mix_in   (mix),
    .key_mode (key_mode),
    .t_out    (t)
  );

  sm4_rk_mem #(
    .DEPTH (ROUND_COUNT)
  ) u_rk_mem (
    .clk   (clk),
    .we    (key_mode),
    .waddr (cnt_r),
    .wdata (word_nxt),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      dec_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < KEY_WORDS; i++) key_r[i] <= '0;
      for (int i = 0; i < 4; i++) x_r[i] <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        // Any key write restarts the expansion from the current key words.
        key_r[cfg_addr] <= cfg_wdata;
        state_r         <= ST_KEY_LOAD;
      end else begin
        unique case (state_r)
          ST_IDLE: begin
            if (in_accept) begin
              x_r[0]  <= in_tdata[63:32];
              x_r[1]  <= in_tdata[31:0];
              x_r[2]  <= in_tdata[127:96];
              x_r[3]  <= in_tdata[95:64];
              dec_r   <= in_tuser[0];
              cnt_r   <= '0;
              state_r <= ST_BLK_RUN;
            end
          end
          ST_KEY_LOAD: begin
            for (int i = 0; i < KEY_WORDS; i++) x_r[i] <= key_r[i] ^ FK[i];
            cnt_r   <= '0;
            state_r <= ST_KEY_RUN;
          end
          ST_KEY_RUN, ST_BLK_RUN: begin
            x_r[0] <= x_r[1];
            x_r[1] <= x_r[2];
            x_r[2] <= x_r[3];
            x_r[3] <= word_nxt;
            cnt_r  <= cnt_nxt;
            if (cnt_r == LAST) begin
              state_r <= key_mode ? ST_IDLE : ST_DONE;
            end
          end
          ST_DONE: begin
            if (out_free) begin
              out_data_r  <= {x_r[1], x_r[0], x_r[3], x_r[2]};
              out_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end
          end
          default: state_r <= ST_IDLE;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/sm4_round_fn.sv @@
// Shared SM4 word transform: byte-wise S-box followed by the data-path
// linear map or the key-schedule linear map. Depends on sm4_pkg.
module sm4_round_fn
  import sm4_pkg::*;
(
  input  logic [WORD_W-1:0] mix_in,
  input  logic              key_mode,
  output logic [WORD_W-1:0] t_out
);

  logic [WORD_W-1:0] s;
  logic [WORD_W-1:0] l_data;
  logic [WORD_W-1:0] l_key;

  assign s      = sub_word(mix_in);
  assign l_data = s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
  assign l_key  = s ^ rotl(s, 13) ^ rotl(s, 23);
  assign t_out  = key_mode ? l_key : l_data;

endmodule

@@ design/sm4_rk_mem.sv @@
// Round key store: one write port, one read port with registered read data.
// Depends on sm4_pkg for the word width.
module sm4_rk_mem
  import sm4_pkg::*;
#(
  parameter int DEPTH = ROUND_COUNT_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/sm4_chk.sv @@
// Port-level checks for the SM4 block cipher, bound to the top level.
// Depends on sm4_pkg and sm4_block_cipher.
module sm4_chk
  import sm4_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [127:0]         out_tdata,
  input logic                 cfg_we
);

  // A block occupies the round unit, so no second request follows at once.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while a block is in progress");

  // A key write starts expansion, during which requests are held off.
  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("request path open during key expansion");

  // A new result only appears at the end of a run, while requests wait.
  a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a finished run");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind sm4_block_cipher sm4_chk u_sm4_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we)
);
